// ----- sv/olist_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the ordered list engine.
package olist_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 6;
  localparam int POS_W   = 6;
  localparam int LEN_W   = 7;

  localparam logic [OP_W-1:0] OP_APPEND  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_DEL_IDX = OP_W'(1);
  localparam logic [OP_W-1:0] OP_DEL_VAL = OP_W'(2);
  localparam logic [OP_W-1:0] OP_FIND    = OP_W'(3);
  localparam logic [OP_W-1:0] OP_READ    = OP_W'(4);

  localparam logic [VALUE_W-1:0] MIN_VALUE = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SH_START,
    ST_SHIFT,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_INDEX,
    RD_SCAN,
    RD_PTR1,
    RD_PTR2
  } rd_src_t;

  typedef enum logic [2:0] {
    RES_FAIL,
    RES_OK,
    RES_FOUND,
    RES_READ,
    RES_READ_MISS
  } res_kind_t;

  typedef struct packed {
    logic      latch_in;
    logic      append;
    logic      shift_wr;
    logic      cnt_dec;
    logic      ptr_load_index;
    logic      ptr_load_match;
    logic      ptr_inc;
    logic      scan_clear;
    logic      scan_step;
    rd_src_t   rd_src;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic not_full;
    logic idx_in;
    logic match;
    logic scan_more;
    logic cmp_pend;
    logic ptr_last;
    logic shift_more;
  } dp_stat_t;

endpackage

// ----- sv/olist_dp.sv -----
// Datapath: entry memory, count, scan and shift pointers, result and output registers.
module olist_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [olist_pkg::VALUE_W-1:0] in_value,
  input  logic        [olist_pkg::INDEX_W-1:0] in_index,
  input  olist_pkg::dp_cmd_t                   cmd,
  output olist_pkg::dp_stat_t                  st,
  output logic                                 out_ok,
  output logic        [olist_pkg::POS_W-1:0]   out_position,
  output logic signed [olist_pkg::VALUE_W-1:0] out_read_value,
  output logic        [olist_pkg::LEN_W-1:0]   out_length
);

  localparam int EXT_W = olist_pkg::CNT_W + 1;
  localparam int CMP_W = olist_pkg::CNT_W + olist_pkg::INDEX_W;

  logic [olist_pkg::VALUE_W-1:0] mem [olist_pkg::CAPACITY];

  logic [olist_pkg::VALUE_W-1:0] value_r;
  logic [olist_pkg::INDEX_W-1:0] index_r;
  logic [olist_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [olist_pkg::ADDR_W-1:0]  ptr_r, ptr_nxt;
  logic [olist_pkg::CNT_W-1:0]   scan_r, scan_nxt;
  logic                          cmp_pend_r;
  logic [olist_pkg::ADDR_W-1:0]  cmp_addr_r;
  logic [olist_pkg::VALUE_W-1:0] rdata_r;
  logic [olist_pkg::ADDR_W-1:0]  rd_addr;
  logic [EXT_W-1:0]              ptr_p1, ptr_p2;

  logic                          res_ok_r;
  logic [olist_pkg::POS_W-1:0]   res_pos_r;
  logic [olist_pkg::VALUE_W-1:0] res_val_r;

  logic                          out_ok_r;
  logic [olist_pkg::POS_W-1:0]   out_pos_r;
  logic [olist_pkg::VALUE_W-1:0] out_val_r;
  logic [olist_pkg::LEN_W-1:0]   out_len_r;

  assign ptr_p1 = EXT_W'(ptr_r) + EXT_W'(1);
  assign ptr_p2 = EXT_W'(ptr_r) + EXT_W'(2);

  always_comb begin
    st.not_full   = (count_r != olist_pkg::CNT_W'(olist_pkg::CAPACITY));
    st.idx_in     = (CMP_W'(index_r) < CMP_W'(count_r));
    st.match      = cmp_pend_r && (rdata_r == value_r);
    st.scan_more  = (scan_r < count_r);
    st.cmp_pend   = cmp_pend_r;
    st.ptr_last   = (ptr_p1 >= EXT_W'(count_r));
    st.shift_more = (ptr_p2 < EXT_W'(count_r));
  end

  always_comb begin
    case (cmd.rd_src)
      olist_pkg::RD_INDEX: rd_addr = olist_pkg::ADDR_W'(index_r);
      olist_pkg::RD_SCAN:  rd_addr = olist_pkg::ADDR_W'(scan_r);
      olist_pkg::RD_PTR1:  rd_addr = olist_pkg::ADDR_W'(ptr_p1);
      olist_pkg::RD_PTR2:  rd_addr = olist_pkg::ADDR_W'(ptr_p2);
      default:             rd_addr = olist_pkg::ADDR_W'(index_r);
    endcase
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[olist_pkg::ADDR_W'(count_r)] <= value_r;
    end else if (cmd.shift_wr) begin
      mem[ptr_r] <= rdata_r;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.append) begin
      count_nxt = count_r + olist_pkg::CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - olist_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_load_index) begin
      ptr_nxt = olist_pkg::ADDR_W'(index_r);
    end else if (cmd.ptr_load_match) begin
      ptr_nxt = cmp_addr_r;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + olist_pkg::ADDR_W'(1);
    end
  end

  always_comb begin
    scan_nxt = scan_r;
    if (cmd.scan_clear) begin
      scan_nxt = '0;
    end else if (cmd.scan_step) begin
      scan_nxt = scan_r + olist_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      cmp_pend_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      cmp_pend_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    scan_r <= scan_nxt;
    if (cmd.scan_step) begin
      cmp_addr_r <= olist_pkg::ADDR_W'(scan_r);
    end
    if (cmd.latch_in) begin
      value_r <= in_value;
      index_r <= in_index;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        olist_pkg::RES_OK: begin
          res_ok_r  <= 1'b1;
          res_pos_r <= '0;
          res_val_r <= '0;
        end
        olist_pkg::RES_FOUND: begin
          res_ok_r  <= 1'b1;
          res_pos_r <= olist_pkg::POS_W'(cmp_addr_r);
          res_val_r <= '0;
        end
        olist_pkg::RES_READ: begin
          res_ok_r  <= 1'b1;
          res_pos_r <= '0;
          res_val_r <= rdata_r;
        end
        olist_pkg::RES_READ_MISS: begin
          res_ok_r  <= 1'b0;
          res_pos_r <= '0;
          res_val_r <= olist_pkg::MIN_VALUE;
        end
        default: begin
          res_ok_r  <= 1'b0;
          res_pos_r <= '0;
          res_val_r <= '0;
        end
      endcase
    end
  end

  // length is taken after every count update of the operation has landed
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok_r  <= res_ok_r;
      out_pos_r <= res_pos_r;
      out_val_r <= res_val_r;
      out_len_r <= olist_pkg::LEN_W'(count_r);
    end
  end

  assign out_ok         = out_ok_r;
  assign out_position   = out_pos_r;
  assign out_read_value = out_val_r;
  assign out_length     = out_len_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= olist_pkg::CNT_W'(olist_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> count_r != '0)
    else $error("count decrement on empty list");
`endif

endmodule

// ----- sv/olist_ctrl.sv -----
// Controller: operation sequencing state machine and output handshake.
module olist_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [olist_pkg::OP_W-1:0]       in_operation,
  output logic                             out_valid,
  input  logic                             out_stall,
  input  olist_pkg::dp_stat_t              st,
  output olist_pkg::dp_cmd_t               cmd
);

  olist_pkg::state_t          state_r, state_nxt;
  logic [olist_pkg::OP_W-1:0] op_r;
  logic                       out_valid_r, out_valid_nxt;
  logic                       in_take;
  logic                       out_free;

  assign in_stall = (state_r != olist_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olist_pkg::ST_IDLE: begin
        if (in_take) state_nxt = olist_pkg::ST_DISPATCH;
      end
      olist_pkg::ST_DISPATCH: begin
        case (op_r)
          olist_pkg::OP_DEL_IDX: begin
            state_nxt = st.idx_in ? olist_pkg::ST_SH_START : olist_pkg::ST_DONE;
          end
          olist_pkg::OP_DEL_VAL, olist_pkg::OP_FIND: begin
            state_nxt = olist_pkg::ST_SCAN;
          end
          olist_pkg::OP_READ: begin
            state_nxt = st.idx_in ? olist_pkg::ST_RD_WAIT : olist_pkg::ST_DONE;
          end
          default: state_nxt = olist_pkg::ST_DONE;
        endcase
      end
      olist_pkg::ST_SCAN: begin
        if (st.match) begin
          state_nxt = (op_r == olist_pkg::OP_DEL_VAL) ? olist_pkg::ST_SH_START
                                                      : olist_pkg::ST_DONE;
        end else if (!st.scan_more && !st.cmp_pend) begin
          state_nxt = olist_pkg::ST_DONE;
        end
      end
      olist_pkg::ST_SH_START: begin
        state_nxt = st.ptr_last ? olist_pkg::ST_DONE : olist_pkg::ST_SHIFT;
      end
      olist_pkg::ST_SHIFT: begin
        if (!st.shift_more) state_nxt = olist_pkg::ST_DONE;
      end
      olist_pkg::ST_RD_WAIT: state_nxt = olist_pkg::ST_DONE;
      olist_pkg::ST_DONE: begin
        if (out_free) state_nxt = olist_pkg::ST_IDLE;
      end
      default: state_nxt = olist_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_src   = olist_pkg::RD_INDEX;
    cmd.res_kind = olist_pkg::RES_FAIL;
    case (state_r)
      olist_pkg::ST_IDLE: begin
        cmd.latch_in = in_take;
      end
      olist_pkg::ST_DISPATCH: begin
        case (op_r)
          olist_pkg::OP_APPEND: begin
            cmd.append   = st.not_full;
            cmd.res_load = 1'b1;
            cmd.res_kind = st.not_full ? olist_pkg::RES_OK : olist_pkg::RES_FAIL;
          end
          olist_pkg::OP_DEL_IDX: begin
            cmd.ptr_load_index = st.idx_in;
            cmd.res_load       = !st.idx_in;
          end
          olist_pkg::OP_DEL_VAL, olist_pkg::OP_FIND: begin
            cmd.scan_clear = 1'b1;
          end
          olist_pkg::OP_READ: begin
            cmd.rd_src   = olist_pkg::RD_INDEX;
            cmd.res_load = !st.idx_in;
            cmd.res_kind = olist_pkg::RES_READ_MISS;
          end
          default: begin
            cmd.res_load = 1'b1;
          end
        endcase
      end
      olist_pkg::ST_SCAN: begin
        // hold the compare address once a match shows up
        if (st.match) begin
          if (op_r == olist_pkg::OP_DEL_VAL) begin
            cmd.ptr_load_match = 1'b1;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_kind = olist_pkg::RES_FOUND;
          end
        end else if (st.scan_more) begin
          cmd.rd_src    = olist_pkg::RD_SCAN;
          cmd.scan_step = 1'b1;
        end else if (!st.cmp_pend) begin
          cmd.res_load = 1'b1;
        end
      end
      olist_pkg::ST_SH_START: begin
        cmd.rd_src = olist_pkg::RD_PTR1;
        if (st.ptr_last) begin
          cmd.cnt_dec  = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_kind = olist_pkg::RES_OK;
        end
      end
      olist_pkg::ST_SHIFT: begin
        // move the entry read last cycle down one slot, fetch the next
        cmd.shift_wr = 1'b1;
        if (st.shift_more) begin
          cmd.rd_src  = olist_pkg::RD_PTR2;
          cmd.ptr_inc = 1'b1;
        end else begin
          cmd.cnt_dec  = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_kind = olist_pkg::RES_OK;
        end
      end
      olist_pkg::ST_RD_WAIT: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = olist_pkg::RES_READ;
      end
      olist_pkg::ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd.res_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olist_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r <= in_operation;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("output word overwritten while stalled");

  a_take_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == olist_pkg::ST_DISPATCH)
    else $error("accepted word not dispatched");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.append && cmd.shift_wr))
    else $error("two memory writes in one cycle");
`endif

endmodule

// ----- sv/ordered_list_engine.sv -----
// Ordered list engine top level: bounded ordered list of signed 32-bit values.
//
// Input channel in_*: operation, value, index; a word is taken when in_valid
// is high and in_stall is low. One operation is in flight at a time; in_stall
// stays high from acceptance until its result is in the output register.
// Output channel out_*: ok, position, read_value, length; one word per input.
// Find and delete-by-value scan the list from entry 0; delete-at-index and
// delete-by-value then shift the entries above the gap down one slot. The
// scan and the shift walk the entry memory one entry per cycle through its
// single registered read port. The next word can be taken in the same cycle
// that out_valid rises.
// A result waiting in the output register does not block the next word: the
// block takes a new input and only waits before its own result if out_stall
// still holds the previous one.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// output word; memory contents are not cleared.
module ordered_list_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [olist_pkg::OP_W-1:0]    in_operation,
  input  logic signed [olist_pkg::VALUE_W-1:0] in_value,
  input  logic        [olist_pkg::INDEX_W-1:0] in_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_ok,
  output logic        [olist_pkg::POS_W-1:0]   out_position,
  output logic signed [olist_pkg::VALUE_W-1:0] out_read_value,
  output logic        [olist_pkg::LEN_W-1:0]   out_length
);

  olist_pkg::dp_cmd_t  cmd;
  olist_pkg::dp_stat_t st;

  olist_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .st           (st),
    .cmd          (cmd)
  );

  olist_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_index       (in_index),
    .cmd            (cmd),
    .st             (st),
    .out_ok         (out_ok),
    .out_position   (out_position),
    .out_read_value (out_read_value),
    .out_length     (out_length)
  );

endmodule

// ----- verif/olist_checker.sv -----
// Checker for the ordered list engine: tracks the list, predicts each result word and compares.
module olist_checker
  import olist_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [OP_W-1:0]           in_operation,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [INDEX_W-1:0]        in_index,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_ok,
  input  logic [POS_W-1:0]          out_position,
  input  logic signed [VALUE_W-1:0] out_read_value,
  input  logic [LEN_W-1:0]          out_length,
  output int                        errors,
  output int                        pending,
  output int                        checked,
  output int                        length_now,
  output int                        peak_length,
  output int                        full_rejects
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                      ok;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] read_value;
    logic [LEN_W-1:0]          length;
  } olist_result_t;

  logic [VALUE_W-1:0] list_mem [CAPACITY];
  int                 list_len = 0;
  int                 peak_len = 0;
  int                 reject_n = 0;
  int                 mismatch_n = 0;
  int                 checked_n = 0;
  olist_result_t      result_q [$];

  // Close the gap left at pos, keeping order.
  function automatic void close_gap(int pos);
    for (int k = pos; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
    list_len--;
  endfunction

  function automatic int first_hit(logic [VALUE_W-1:0] value);
    for (int k = 0; k < list_len; k++) begin
      if (list_mem[k] == value) return k;
    end
    return -1;
  endfunction

  function automatic olist_result_t step_list(logic [OP_W-1:0] op,
                                              logic [VALUE_W-1:0] value,
                                              logic [INDEX_W-1:0] index);
    olist_result_t res;
    int            hit;
    res = '0;
    hit = -1;
    case (op)
      OP_APPEND: begin
        if (list_len < CAPACITY) begin
          list_mem[list_len] = value;
          list_len++;
          res.ok = 1'b1;
        end else begin
          reject_n++;
        end
      end
      OP_DEL_IDX: begin
        if (int'(index) < list_len) begin
          close_gap(int'(index));
          res.ok = 1'b1;
        end
      end
      OP_DEL_VAL: begin
        hit = first_hit(value);
        if (hit >= 0) begin
          close_gap(hit);
          res.ok = 1'b1;
        end
      end
      OP_FIND: begin
        hit = first_hit(value);
        if (hit >= 0) begin
          res.position = POS_W'(hit);
          res.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(index) < list_len) begin
          res.read_value = list_mem[index];
          res.ok = 1'b1;
        end else begin
          res.read_value = MIN_VALUE;
        end
      end
      default: ;
    endcase
    res.length = LEN_W'(list_len);
    if (list_len > peak_len) peak_len = list_len;
    return res;
  endfunction

  task automatic note_mismatch(string what, olist_result_t want, olist_result_t got);
    mismatch_n++;
    if (mismatch_n <= 10) begin
      $display("%0t mismatch, %s: expected ok=%0b pos=%0d rd=%0d len=%0d", $realtime, what,
               want.ok, want.position, want.read_value, want.length);
      $display("    got ok=%0b pos=%0d rd=%0d len=%0d",
               got.ok, got.position, got.read_value, got.length);
    end
  endtask

  always @(posedge clk) begin
    olist_result_t got;
    olist_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_ok, out_position, out_read_value, out_length};
        checked_n++;
        if (result_q.size() == 0) begin
          note_mismatch("no result pending", '0, got);
        end else begin
          want = result_q.pop_front();
          if (got.ok !== want.ok || got.position !== want.position ||
              got.read_value !== want.read_value || got.length !== want.length) begin
            note_mismatch("wrong field", want, got);
          end
        end
      end
      if (in_valid && !in_stall) result_q.push_back(step_list(in_operation, in_value, in_index));
    end
    errors       <= mismatch_n;
    pending      <= result_q.size();
    checked      <= checked_n;
    length_now   <= list_len;
    peak_length  <= peak_len;
    full_rejects <= reject_n;
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the ordered list engine: clock, reset, stimulus, stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import olist_pkg::*;

  // Operation codes the block must treat as no-ops.
  localparam logic [OP_W-1:0] OP_SPARE5 = OP_W'(5);
  localparam logic [OP_W-1:0] OP_SPARE6 = OP_W'(6);
  localparam logic [OP_W-1:0] OP_SPARE7 = OP_W'(7);

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           in_operation = OP_APPEND;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic [INDEX_W-1:0]        in_index = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_ok;
  logic [POS_W-1:0]          out_position;
  logic signed [VALUE_W-1:0] out_read_value;
  logic [LEN_W-1:0]          out_length;

  int errors, pending, checked, length_now, peak_length, full_rejects;
  int words_sent = 0;
  int directed_n = 0;
  bit calm = 1'b0;

  always #6 clk = ~clk;

  ordered_list_engine u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_operation, .in_value, .in_index,
    .out_valid, .out_stall, .out_ok, .out_position, .out_read_value, .out_length
  );

  olist_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_operation, .in_value, .in_index,
    .out_valid, .out_stall, .out_ok, .out_position, .out_read_value, .out_length,
    .errors, .pending, .checked, .length_now, .peak_length, .full_rejects
  );

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 24);

  initial begin
    #10ms;
    $display("[ordered_list_engine] ERROR");
    $finish;
  end

  task automatic send_word(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                           logic [INDEX_W-1:0] index);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= value;
    in_index     <= index;
    // Hold the word until the block takes it.
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_op(mix_t mix);
    int r, a, di, dv, fd;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   begin a = 65; di = 70; dv = 75; fd = 85; end
      MIX_SHRINK: begin a = 15; di = 40; dv = 65; fd = 80; end
      default:    begin a = 35; di = 47; dv = 59; fd = 77; end
    endcase
    if (r < a)  return OP_APPEND;
    if (r < di) return OP_DEL_IDX;
    if (r < dv) return OP_DEL_VAL;
    if (r < fd) return OP_FIND;
    if (r < 97) return OP_READ;
    if (r == 97) return OP_SPARE5;
    if (r == 98) return OP_SPARE6;
    return OP_SPARE7;
  endfunction

  // Mostly a small pool so finds and deletes hit, duplicates included.
  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) >= 55) return $urandom();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return 32'hffff_ffff;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      default: return VALUE_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (length_now > 0 && r < 50) return INDEX_W'($urandom_range(0, length_now - 1));
    if (r < 65) return INDEX_W'((length_now > 63) ? 63 : length_now);
    return INDEX_W'($urandom_range(0, 63));
  endfunction

  task automatic run_phase(mix_t mix, int count, bit no_idle);
    calm = no_idle;
    repeat (count) send_word(pick_op(mix), pick_value(), pick_index());
    drain_results();
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: every lookup misses.
    send_word(OP_READ, '0, 6'd0);
    send_word(OP_DEL_IDX, '0, 6'd0);
    send_word(OP_DEL_VAL, '0, 6'd0);
    send_word(OP_FIND, '0, 6'd0);
    send_word(OP_APPEND, 32'h8000_0000, 6'd63);
    send_word(OP_APPEND, 32'h7fff_ffff, 6'd0);
    send_word(OP_APPEND, 32'hffff_ffff, 6'd0);
    send_word(OP_APPEND, '0, 6'd0);
    send_word(OP_APPEND, 32'h7fff_ffff, 6'd0);
    // First match wins among duplicates.
    send_word(OP_FIND, 32'h7fff_ffff, 6'd0);
    send_word(OP_FIND, 32'd12345, 6'd0);
    // A stored minimum value must still read back with ok set.
    send_word(OP_READ, '0, 6'd0);
    send_word(OP_READ, '0, 6'd63);
    send_word(OP_READ, '0, 6'd4);
    send_word(OP_READ, '0, 6'd5);
    send_word(OP_DEL_VAL, 32'h7fff_ffff, 6'd0);
    send_word(OP_FIND, 32'h7fff_ffff, 6'd0);
    send_word(OP_DEL_IDX, '0, 6'd0);
    send_word(OP_DEL_IDX, '0, 6'd3);
    send_word(OP_DEL_VAL, 32'd777, 6'd0);
    send_word(OP_SPARE5, 32'hffff_ffff, 6'd63);
    send_word(OP_SPARE6, 32'h8000_0000, 6'd1);
    send_word(OP_SPARE7, 32'h7fff_ffff, 6'd0);
    send_word(OP_DEL_IDX, '0, 6'd2);
    send_word(OP_READ, '0, 6'd1);
    drain_results();
    directed_n = words_sent;

    // Fill past capacity, empty out, then mix; one stretch runs without idling.
    run_phase(MIX_GROW, 120, 1'b0);
    run_phase(MIX_GROW, 100, 1'b1);
    run_phase(MIX_SHRINK, 150, 1'b0);
    run_phase(MIX_BALANCED, 100, 1'b0);
    run_phase(MIX_GROW, 120, 1'b0);
    run_phase(MIX_SHRINK, 110, 1'b0);

    repeat (150) @(posedge clk);
    $display("coverage: %0d words sent (%0d directed), %0d results checked",
             words_sent, directed_n, checked);
    $display("coverage: list peaked at %0d of %0d entries, %0d appends refused when full",
             peak_length, CAPACITY, full_rejects);
    if (errors == 0 && pending == 0) begin
      $display("[ordered_list_engine] OK");
    end else begin
      $display("[ordered_list_engine] ERROR");
    end
    $finish;
  end

endmodule
